/* sv/binary_min_heap_queue_assert.svh */
// ----------------------------------------------------------------------------
// Binary min-heap queue assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define BMHQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types and constants shared by the binary min-heap queue modules.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int STATUS_W      = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LD,
    S_DN_CHK,
    S_DN_CMP,
    S_FINISH
  } state_t;

endpackage

/* sv/bmhq_store.sv */
// ----------------------------------------------------------------------------
// bmhq_store
// Heap key store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bmhq_store #(
  parameter int DEPTH = bmhq_pkg::CAPACITY_DEF,
  parameter int WIDTH = bmhq_pkg::KEY_WIDTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_a_addr,
  input  logic [AW-1:0]    rd_b_addr,
  output logic [WIDTH-1:0] rd_a_data,
  output logic [WIDTH-1:0] rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

/* sv/binary_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue: insert sifts up, pop returns the root and sifts
// the last entry down, one level at a time through a shared store.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid in_ready in_cmd in_key         | in
//  result  | out_valid out_ready out_min_value       | out
//          | out_status out_occupancy                |
//
//  Insert climbs one level per step until it reaches the root or a compare
//  stops it; pop reads the root and the last entry, then sinks that entry the
//  same way; full or empty goes straight to the result. Each level is one store
//  read then one compare and write, so the work is bounded by the heap depth.
//  Reset clears the count and control; store contents need no clearing.
//  A new item is taken while the result waits; a finished one waits for it.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_assert.svh"

module binary_min_heap_queue #(
  parameter int CAPACITY  = bmhq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int PW = CW + 1,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_cmd,
  input  logic [KEY_WIDTH-1:0]    in_key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [KEY_WIDTH-1:0]    out_min_value,
  output logic [bmhq_pkg::STATUS_W-1:0] out_status,
  output logic [CW-1:0]           out_occupancy
);

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [PW-1:0] ONE_P = PW'(1);

  bmhq_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [KEY_WIDTH-1:0] min_r, min_nxt;
  bmhq_pkg::status_t status_r, status_nxt;

  logic                 out_valid_r;
  logic [KEY_WIDTH-1:0] out_min_r;
  bmhq_pkg::status_t    out_status_r;
  logic [CW-1:0]        out_occ_r;
  logic                 out_load;

  logic                 wr_en;
  logic [PW-1:0]        wr_pos;
  logic [KEY_WIDTH-1:0] wr_data;
  logic [AW-1:0]        rd_a_addr, rd_b_addr;
  logic [KEY_WIDTH-1:0] rd_a_data, rd_b_data;

  logic [PW-1:0] count_pos, left_pos, right_pos, parent_pos, pick_pos;
  logic [PW-1:0] rd_a_pos, rd_b_pos;
  logic [PW-1:0] wr_m1, rd_a_m1, rd_b_m1;
  logic          take_right;
  logic [KEY_WIDTH-1:0] pick_val;

  logic          res_full, res_empty, res_blank;

  assign count_pos  = PW'(count_r);
  assign left_pos   = {pos_r[PW-2:0], 1'b0};
  assign right_pos  = {pos_r[PW-2:0], 1'b1};
  assign parent_pos = pos_r >> 1;

  // smaller child, left on a tie; a right child past the count is ignored
  assign take_right = (right_pos <= count_pos) && (rd_b_data < rd_a_data);
  assign pick_val   = take_right ? rd_b_data : rd_a_data;
  assign pick_pos   = take_right ? right_pos : left_pos;

  // heap positions are one-based, store addresses zero-based
  always_comb begin
    case (state_r)
      bmhq_pkg::S_POP_RD: begin
        rd_a_pos = ONE_P;
        rd_b_pos = count_pos;
      end
      bmhq_pkg::S_UP_CHK, bmhq_pkg::S_UP_CMP: begin
        rd_a_pos = parent_pos;
        rd_b_pos = parent_pos;
      end
      default: begin
        rd_a_pos = left_pos;
        rd_b_pos = right_pos;
      end
    endcase
  end

  assign rd_a_m1   = rd_a_pos - ONE_P;
  assign rd_b_m1   = rd_b_pos - ONE_P;
  assign wr_m1     = wr_pos - ONE_P;
  assign rd_a_addr = rd_a_m1[AW-1:0];
  assign rd_b_addr = rd_b_m1[AW-1:0];

  bmhq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_m1[AW-1:0]),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmhq_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    min_r    <= min_nxt;
    status_r <= status_nxt;
  end

  // the travelling key stays in key_r and is written where it settles; displaced entries are written as it moves
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    min_nxt    = min_r;
    status_nxt = status_r;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    wr_en      = 1'b0;
    wr_pos     = pos_r;
    wr_data    = key_r;

    case (state_r)
      bmhq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          min_nxt    = '0;
          status_nxt = bmhq_pkg::STATUS_OK;
          if (in_cmd == bmhq_pkg::CMD_INSERT) begin
            if (count_r == CAP_C) begin
              status_nxt = bmhq_pkg::STATUS_FULL;
              state_nxt  = bmhq_pkg::S_FINISH;
            end else begin
              count_nxt = count_r + CW'(1);
              pos_nxt   = count_pos + ONE_P;
              key_nxt   = in_key;
              state_nxt = bmhq_pkg::S_UP_CHK;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = bmhq_pkg::STATUS_EMPTY;
              state_nxt  = bmhq_pkg::S_FINISH;
            end else begin
              state_nxt = bmhq_pkg::S_POP_RD;
            end
          end
        end
      end

      bmhq_pkg::S_UP_CHK: begin
        if (pos_r == ONE_P) begin
          wr_en     = 1'b1;
          state_nxt = bmhq_pkg::S_FINISH;
        end else begin
          state_nxt = bmhq_pkg::S_UP_CMP;
        end
      end

      bmhq_pkg::S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_a_data > key_r) begin
          wr_data   = rd_a_data;
          pos_nxt   = parent_pos;
          state_nxt = bmhq_pkg::S_UP_CHK;
        end else begin
          state_nxt = bmhq_pkg::S_FINISH;
        end
      end

      bmhq_pkg::S_POP_RD: begin
        state_nxt = bmhq_pkg::S_POP_LD;
      end

      bmhq_pkg::S_POP_LD: begin
        min_nxt   = rd_a_data;
        key_nxt   = rd_b_data;
        count_nxt = count_r - CW'(1);
        pos_nxt   = ONE_P;
        state_nxt = bmhq_pkg::S_DN_CHK;
      end

      bmhq_pkg::S_DN_CHK: begin
        if (left_pos > count_pos) begin
          wr_en     = 1'b1;
          state_nxt = bmhq_pkg::S_FINISH;
        end else begin
          state_nxt = bmhq_pkg::S_DN_CMP;
        end
      end

      bmhq_pkg::S_DN_CMP: begin
        wr_en = 1'b1;
        if (pick_val < key_r) begin
          wr_data   = pick_val;
          pos_nxt   = pick_pos;
          state_nxt = bmhq_pkg::S_DN_CHK;
        end else begin
          state_nxt = bmhq_pkg::S_FINISH;
        end
      end

      bmhq_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = bmhq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_min_r    <= min_r;
      out_status_r <= status_r;
      out_occ_r    <= count_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

  assign res_full  = out_valid && (out_status == bmhq_pkg::STATUS_FULL);
  assign res_empty = out_valid && (out_status == bmhq_pkg::STATUS_EMPTY);
  assign res_blank = (out_occupancy == '0) && (out_min_value == '0);

  `BMHQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CAP_C, "heap count beyond capacity")
  `BMHQ_ASSERT_NOW(a_full_occ, res_full, out_occupancy == CAP_C, "full status, store not full")
  `BMHQ_ASSERT_NOW(a_empty_res, res_empty, res_blank, "empty status with data")
  `BMHQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item taken while busy")

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_min_heap_queue. A directed table covers the
// key extremes, both commands, pops from an empty store and ties between
// children. Random phases then fill the store past full, drain it past empty
// and mix the two. Both handshakes idle at random. Each accepted item is run
// through a local heap model, and every result is checked field by field
// against the oldest outstanding expected result.
// ----------------------------------------------------------------------------
module tb;

  localparam int HEAP_CAP  = bmhq_pkg::CAPACITY_DEF;
  localparam int KEY_W     = bmhq_pkg::KEY_WIDTH_DEF;
  localparam int OCC_W     = $clog2(HEAP_CAP + 1);
  localparam int RAND_ITEMS = 1600;

  typedef struct packed {
    logic [KEY_W-1:0]  min_value;
    bmhq_pkg::status_t status;
    logic [OCC_W-1:0]  occupancy;
  } heap_result_t;

  typedef struct packed {
    logic         cmd;
    logic [KEY_W-1:0] key;
    logic         has_want;  // expected result typed in below
    heap_result_t want;
  } directed_row_t;

  localparam int N_DIRECTED = 25;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  localparam logic C_INS = bmhq_pkg::CMD_INSERT;
  localparam logic C_POP = bmhq_pkg::CMD_POP;
  localparam bmhq_pkg::status_t S_OK    = bmhq_pkg::STATUS_OK;
  localparam bmhq_pkg::status_t S_EMPTY = bmhq_pkg::STATUS_EMPTY;

  localparam directed_row_t DIRECTED [0:N_DIRECTED-1] = '{
    '{C_POP, '0,            1'b1, '{'0,      S_EMPTY, 7'd0}},
    '{C_POP, KEY_MAX,       1'b1, '{'0,      S_EMPTY, 7'd0}},
    '{C_INS, KEY_MAX,       1'b1, '{'0,      S_OK,    7'd1}},
    '{C_INS, '0,            1'b1, '{'0,      S_OK,    7'd2}},
    '{C_POP, '0,            1'b1, '{'0,      S_OK,    7'd1}},
    '{C_POP, '0,            1'b1, '{KEY_MAX, S_OK,    7'd0}},
    '{C_POP, '0,            1'b1, '{'0,      S_EMPTY, 7'd0}},
    // equal keys, so children tie on the way down
    '{C_INS, 32'd5,         1'b0, '0},
    '{C_INS, 32'd5,         1'b0, '0},
    '{C_INS, 32'd5,         1'b0, '0},
    '{C_INS, 32'd3,         1'b0, '0},
    '{C_INS, 32'h8000_0000, 1'b0, '0},
    '{C_INS, 32'h7FFF_FFFF, 1'b0, '0},
    '{C_INS, 32'd1,         1'b0, '0},
    '{C_INS, 32'd5,         1'b0, '0},
    '{C_INS, 32'hAAAA_AAAA, 1'b0, '0},
    '{C_INS, 32'h5555_5555, 1'b0, '0},
    '{C_POP, 32'hFFFF_0000, 1'b0, '0},
    '{C_POP, '0,            1'b0, '0},
    '{C_POP, '0,            1'b0, '0},
    '{C_POP, '0,            1'b0, '0},
    '{C_POP, '0,            1'b0, '0},
    '{C_POP, '0,            1'b0, '0},
    '{C_POP, '0,            1'b0, '0},
    '{C_POP, '0,            1'b0, '0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_cmd;
  logic [KEY_W-1:0] in_key;
  logic             out_valid;
  logic             out_ready;
  logic [KEY_W-1:0] out_min_value;
  logic [bmhq_pkg::STATUS_W-1:0] out_status;
  logic [OCC_W-1:0] out_occupancy;

  binary_min_heap_queue u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_min_value (out_min_value),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  // local heap, one-based like the block's heap positions
  logic [KEY_W-1:0] heap_mem [1:HEAP_CAP];
  int               heap_count;

  heap_result_t pending_results [$];
  int           mismatch_count;
  int           items_sent;
  bit           sender_burst;
  bit           hold_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic heap_result_t heap_apply(input logic cmd, input logic [KEY_W-1:0] key);
    heap_result_t     res;
    int               pos;
    int               up;
    int               left;
    int               pick;
    bit               done;
    logic [KEY_W-1:0] tmp;
    res = '0;
    res.status = bmhq_pkg::STATUS_OK;
    if (cmd == bmhq_pkg::CMD_INSERT) begin
      if (heap_count >= HEAP_CAP) begin
        res.status = bmhq_pkg::STATUS_FULL;
      end else begin
        heap_count++;
        heap_mem[heap_count] = key;
        pos = heap_count;
        done = 1'b0;
        while (pos > 1 && !done) begin
          up = pos / 2;
          if (heap_mem[up] <= heap_mem[pos]) begin
            done = 1'b1;
          end else begin
            tmp = heap_mem[up];
            heap_mem[up] = heap_mem[pos];
            heap_mem[pos] = tmp;
            pos = up;
          end
        end
      end
    end else begin
      if (heap_count == 0) begin
        res.status = bmhq_pkg::STATUS_EMPTY;
      end else begin
        res.min_value = heap_mem[1];
        heap_mem[1] = heap_mem[heap_count];
        heap_count--;
        pos = 1;
        done = 1'b0;
        while (!done) begin
          left = pos * 2;
          if (left > heap_count) begin
            done = 1'b1;
          end else begin
            pick = left;
            // left child wins a tie
            if (left + 1 <= heap_count && heap_mem[left + 1] < heap_mem[left]) pick = left + 1;
            if (heap_mem[pick] >= heap_mem[pos]) begin
              done = 1'b1;
            end else begin
              tmp = heap_mem[pick];
              heap_mem[pick] = heap_mem[pos];
              heap_mem[pos] = tmp;
              pos = pick;
            end
          end
        end
      end
    end
    res.occupancy = heap_count[OCC_W-1:0];
    return res;
  endfunction

  // Offer one item and hold it until taken; the gap after it is random unless the sender is in a burst.
  task automatic offer_item(input logic cmd, input logic [KEY_W-1:0] key,
                            input bit use_want, input heap_result_t want);
    heap_result_t pred;
    int           gap;
    int           r;
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    do @(posedge clk); while (!in_ready);
    pred = heap_apply(cmd, key);
    pending_results.push_back(use_want ? want : pred);
    items_sent++;
    gap = 0;
    if (!sender_burst) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(10, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // result side: check accepted items, then choose the next ready level
  initial begin : result_side
    heap_result_t got;
    heap_result_t want;
    int           ready_left;
    int           r;
    bit           hold_done;
    logic         next_ready;
    out_ready  = 1'b0;
    ready_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = '{out_min_value, out_status, out_occupancy};
        if (pending_results.size() == 0) begin
          $error("unexpected result: min_value %h status %0d occupancy %0d",
                 got.min_value, got.status, got.occupancy);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.min_value !== want.min_value) begin
            $error("min_value: expected %h, got %h", want.min_value, got.min_value);
            mismatch_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
          end
          if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
            mismatch_count++;
          end
        end
      end
      next_ready = out_ready;
      if (!hold_done && hold_req) begin
        // long back-pressure so the result is held and the block stalls its input
        hold_done  = 1'b1;
        next_ready = 1'b0;
        ready_left = 300;
      end else if (ready_left > 0) begin
        ready_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          next_ready = 1'b1;
          ready_left = $urandom_range(1, 12);
        end else if (r < 85) begin
          next_ready = 1'b0;
          ready_left = $urandom_range(1, 3);
        end else if (r < 95) begin
          next_ready = 1'b0;
          ready_left = $urandom_range(15, 50);
        end else begin
          next_ready = 1'b1;
          ready_left = $urandom_range(100, 200);
        end
      end
      out_ready <= next_ready;
    end
  end

  initial begin : stimulus
    int           phase;
    int           phase_len;
    int           pop_pct;
    int           r;
    logic         cmd;
    logic [KEY_W-1:0] key;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = bmhq_pkg::CMD_INSERT;
    in_key         = '0;
    heap_count     = 0;
    mismatch_count = 0;
    items_sent     = 0;
    sender_burst   = 1'b0;
    hold_req       = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_item(DIRECTED[i].cmd, DIRECTED[i].key, DIRECTED[i].has_want, DIRECTED[i].want);
    end
    drain_results();

    phase = 0;
    while (items_sent < N_DIRECTED + RAND_ITEMS) begin
      case (phase % 4)
        0:       begin pop_pct = 10; phase_len = $urandom_range(90, 120); end  // fill past full
        2:       begin pop_pct = 90; phase_len = $urandom_range(90, 120); end  // drain past empty
        default: begin pop_pct = $urandom_range(30, 70); phase_len = $urandom_range(40, 100); end
      endcase
      // receiver holds off while this long phase keeps offering
      if (phase == 4) hold_req = 1'b1;
      sender_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len; i++) begin
        cmd = ($urandom_range(0, 99) < pop_pct) ? bmhq_pkg::CMD_POP : bmhq_pkg::CMD_INSERT;
        r = $urandom_range(0, 99);
        if (r < 50)      key = $urandom;
        else if (r < 85) key = $urandom_range(0, 15);  // many duplicates
        else if (r < 92) key = '0;
        else             key = KEY_MAX;
        offer_item(cmd, key, 1'b0, '0);
      end
      if (phase % 2 == 1) drain_results();
      phase++;
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
